// ===== hw/rtl/bdms_pkg.sv =====
// ----------------------------------------------------------------------------
// bdms_pkg
// Shared types, register map and format decode for the mode selector.
// ----------------------------------------------------------------------------
package bdms_pkg;

    localparam logic [15:0] NO_MODE = 16'hFFFF;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_WIDTH    = 3'd0,
        REG_TARGET_HEIGHT   = 3'd1,
        REG_TARGET_DEPTH    = 3'd2,
        REG_ATTR_MUST_SET   = 3'd3,
        REG_ATTR_MUST_CLEAR = 3'd4
    } t_reg_idx;

    localparam logic [15:0] RST_TARGET_WIDTH  = 16'd1024;
    localparam logic [15:0] RST_TARGET_HEIGHT = 16'd768;
    localparam logic [7:0]  RST_TARGET_DEPTH  = 8'd32;

    // memory model codes
    localparam logic [7:0] MM_TEXT   = 8'd0;
    localparam logic [7:0] MM_PACKED = 8'd4;
    localparam logic [7:0] MM_DIRECT = 8'd6;

    localparam logic [7:0] DEPTH_4  = 8'd4;
    localparam logic [7:0] DEPTH_8  = 8'd8;
    localparam logic [7:0] DEPTH_15 = 8'd15;
    localparam logic [7:0] DEPTH_16 = 8'd16;
    localparam logic [7:0] DEPTH_32 = 8'd32;
    localparam logic [7:0] MASK_5   = 8'd5;
    localparam logic [7:0] MASK_8   = 8'd8;
    localparam logic [7:0] DEPTH_NONE = 8'd0;

    typedef struct packed {
        logic [15:0] target_width;
        logic [15:0] target_height;
        logic [7:0]  target_depth;
        logic [15:0] attr_must_set;
        logic [15:0] attr_must_clear;
    } t_cfg;

    typedef struct packed {
        logic        start_list;
        logic [15:0] mode_number;
        logic        info_ok;
        logic [15:0] mode_attrs;
        logic [15:0] x_res;
        logic [15:0] y_res;
        logic [7:0]  pixel_bits;
        logic [7:0]  memory_model;
        logic [7:0]  red_size;
        logic [7:0]  green_size;
        logic [7:0]  blue_size;
    } t_item;

    typedef struct packed {
        logic [15:0] mode;
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  depth;
        logic        exact;
    } t_choice;

    localparam t_choice CHOICE_NONE = '{
        mode:   NO_MODE,
        width:  16'd0,
        height: 16'd0,
        depth:  DEPTH_NONE,
        exact:  1'b0
    };

    // Normalized depth, or zero for an unsupported format.
    function automatic logic [7:0] format_depth(
        input logic [7:0] bits,
        input logic [7:0] model,
        input logic [7:0] r,
        input logic [7:0] g,
        input logic [7:0] b
    );
        logic [7:0] d;
        d = DEPTH_NONE;
        if (bits == DEPTH_4 && model == MM_TEXT) begin
            d = DEPTH_4;
        end else if (bits == DEPTH_8 && model == MM_PACKED) begin
            d = DEPTH_8;
        end else if ((bits == DEPTH_16 || bits == DEPTH_15) && model == MM_DIRECT &&
                     r == MASK_5 && g == MASK_5 && b == MASK_5) begin
            d = DEPTH_16;
        end else if (bits == DEPTH_32 && model == MM_DIRECT &&
                     r == MASK_8 && g == MASK_8 && b == MASK_8) begin
            d = DEPTH_32;
        end
        return d;
    endfunction

endpackage

// ===== hw/rtl/bdms_if.sv =====
// ----------------------------------------------------------------------------
// bdms_if
// Valid/ready channels for mode beats, result beats and register writes.
// ----------------------------------------------------------------------------
interface bdms_in_if;
    logic        valid;
    logic        ready;
    logic        start_list;
    logic [15:0] mode_number;
    logic        info_ok;
    logic [15:0] mode_attrs;
    logic [15:0] x_res;
    logic [15:0] y_res;
    logic [7:0]  pixel_bits;
    logic [7:0]  memory_model;
    logic [7:0]  red_size;
    logic [7:0]  green_size;
    logic [7:0]  blue_size;

    modport source (
        output valid, start_list, mode_number, info_ok, mode_attrs, x_res, y_res,
               pixel_bits, memory_model, red_size, green_size, blue_size,
        input  ready
    );
    modport sink (
        input  valid, start_list, mode_number, info_ok, mode_attrs, x_res, y_res,
               pixel_bits, memory_model, red_size, green_size, blue_size,
        output ready
    );
endinterface

interface bdms_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] chosen_mode;
    logic [15:0] chosen_width;
    logic [15:0] chosen_height;
    logic [7:0]  chosen_depth;
    logic        exact_found;

    modport source (
        output valid, chosen_mode, chosen_width, chosen_height, chosen_depth,
               exact_found,
        input  ready
    );
    modport sink (
        input  valid, chosen_mode, chosen_width, chosen_height, chosen_depth,
               exact_found,
        output ready
    );
endinterface

interface bdms_cfg_if;
    import bdms_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] idx;
    logic [15:0]          wdata;

    modport source (output valid, idx, wdata, input ready);
    modport sink   (input valid, idx, wdata, output ready);
endinterface

// ===== hw/rtl/bdms_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bdms_cfg_regs
// Target size/depth and attribute mask registers with write decode.
// ----------------------------------------------------------------------------
module bdms_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bdms_cfg_if.sink       i_cfg,
    output bdms_pkg::t_cfg o_cfg
);
    import bdms_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_width    <= RST_TARGET_WIDTH;
            r_cfg.target_height   <= RST_TARGET_HEIGHT;
            r_cfg.target_depth    <= RST_TARGET_DEPTH;
            r_cfg.attr_must_set   <= '0;
            r_cfg.attr_must_clear <= '0;
        end else if (i_cfg.valid) begin
            // indexes past the map are dropped
            unique case (t_reg_idx'(i_cfg.idx))
                REG_TARGET_WIDTH:    r_cfg.target_width    <= i_cfg.wdata;
                REG_TARGET_HEIGHT:   r_cfg.target_height   <= i_cfg.wdata;
                REG_TARGET_DEPTH:    r_cfg.target_depth    <= i_cfg.wdata[7:0];
                REG_ATTR_MUST_SET:   r_cfg.attr_must_set   <= i_cfg.wdata;
                REG_ATTR_MUST_CLEAR: r_cfg.attr_must_clear <= i_cfg.wdata;
                default: ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/bdms_judge.sv =====
// ----------------------------------------------------------------------------
// bdms_judge
// Judges one mode against the masks, targets and the saved choice and
// gives the choice after it.
// ----------------------------------------------------------------------------
module bdms_judge (
    input  bdms_pkg::t_item   i_item,
    input  bdms_pkg::t_cfg    i_cfg,
    input  bdms_pkg::t_choice i_best,
    output bdms_pkg::t_choice o_next
);
    import bdms_pkg::*;

    t_choice    w_base;
    logic [7:0] w_depth;
    logic       w_ok;
    logic       w_exact;
    logic       w_reject;

    always_comb begin
        w_base = i_item.start_list ? CHOICE_NONE : i_best;

        w_depth = format_depth(i_item.pixel_bits, i_item.memory_model,
                               i_item.red_size, i_item.green_size, i_item.blue_size);

        w_ok = i_item.info_ok &&
               ((i_item.mode_attrs & i_cfg.attr_must_set) == i_cfg.attr_must_set) &&
               ((i_item.mode_attrs & i_cfg.attr_must_clear) == 16'd0) &&
               (w_depth != DEPTH_NONE) &&
               (i_item.x_res <= i_cfg.target_width) &&
               (i_item.y_res <= i_cfg.target_height);

        w_exact = (i_item.x_res == i_cfg.target_width) &&
                  (i_item.y_res == i_cfg.target_height) &&
                  (w_depth == i_cfg.target_depth);

        // same size with no more depth, or smaller in any dimension
        w_reject = (i_item.x_res == w_base.width && i_item.y_res == w_base.height &&
                    w_depth <= w_base.depth) ||
                   (i_item.x_res < w_base.width) || (i_item.y_res < w_base.height) ||
                   (w_depth < w_base.depth);

        o_next = w_base;
        if (!w_base.exact && w_ok && (w_exact || !w_reject)) begin
            o_next.mode   = i_item.mode_number;
            o_next.width  = i_item.x_res;
            o_next.height = i_item.y_res;
            o_next.depth  = w_depth;
            o_next.exact  = w_exact;
        end
    end

endmodule

// ===== hw/rtl/best_display_mode_selector_top.sv =====
// ----------------------------------------------------------------------------
// best_display_mode_selector_top
// Keeps the best display mode of a descriptor stream; one result per mode.
// ----------------------------------------------------------------------------
// Path: a mode beat accepted into the input register is judged and lands in
// the result register, which drives the result beat.
// Throughput: one mode per cycle unless the result is stalled; the judge is
// one compare level from input to result register, which holds the choice.
// Reset (synchronous, active low): registers take their defaults, the choice
// is cleared to no mode, both pipeline slots empty.
module best_display_mode_selector_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bdms_cfg_if.sink   i_cfg,
    bdms_in_if.sink    i_in,
    bdms_out_if.source o_out
);
    import bdms_pkg::*;

    t_cfg    w_cfg;
    t_item   w_item;
    t_item   r_item;
    logic    r_item_vld;
    t_choice r_best;
    t_choice w_next;
    logic    r_out_vld;
    logic    w_adv;

    bdms_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    assign w_item = '{
        start_list:   i_in.start_list,
        mode_number:  i_in.mode_number,
        info_ok:      i_in.info_ok,
        mode_attrs:   i_in.mode_attrs,
        x_res:        i_in.x_res,
        y_res:        i_in.y_res,
        pixel_bits:   i_in.pixel_bits,
        memory_model: i_in.memory_model,
        red_size:     i_in.red_size,
        green_size:   i_in.green_size,
        blue_size:    i_in.blue_size
    };

    bdms_judge u_judge (
        .i_item (r_item),
        .i_cfg  (w_cfg),
        .i_best (r_best),
        .o_next (w_next)
    );

    // the choice only moves when a judged beat lands in the result slot
    assign w_adv      = r_item_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_item_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_best     <= CHOICE_NONE;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_item_vld <= 1'b1;
            end else if (w_adv) begin
                r_item_vld <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
                r_best    <= w_next;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= w_item;
        end
    end

    assign o_out.valid         = r_out_vld;
    assign o_out.chosen_mode   = r_best.mode;
    assign o_out.chosen_width  = r_best.width;
    assign o_out.chosen_height = r_best.height;
    assign o_out.chosen_depth  = r_best.depth;
    assign o_out.exact_found   = r_best.exact;

endmodule
